FILE: design/mnsg_pkg.sv
// shared types and constants for the midi note strum gate scheduler
// no dependencies
package mnsg_pkg;

    // input commands
    localparam logic [2:0] CmdPlay     = 3'd0;
    localparam logic [2:0] CmdAgePend  = 3'd1;
    localparam logic [2:0] CmdAgeBank  = 3'd2;
    localparam logic [2:0] CmdKillBank = 3'd3;
    localparam logic [2:0] CmdAllOff   = 3'd4;

    // register indexes
    localparam logic RegOutChannel = 1'b0;
    localparam logic RegDestination = 1'b1;

    // midi constants
    localparam logic [7:0] StatusOff = 8'h80;
    localparam logic [7:0] StatusOn  = 8'h90;
    localparam logic [7:0] StatusCc  = 8'hB0;
    localparam logic [6:0] CcAllOff  = 7'd123;
    localparam int         NumPitches = 128;
    localparam int         MaxResults = 32;

    // one outgoing message
    typedef struct packed {
        logic [6:0] data_two;
        logic [6:0] data_one;
        logic [7:0] status_byte;
        logic [3:0] route;
    } t_msg;

    // per-pitch record
    typedef struct packed {
        logic [15:0] gate;
        logic [3:0]  channel;
        logic [3:0]  route;
    } t_pitch_rec;

    // pending slot record
    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [15:0] gate;
        logic [15:0] delay;
        logic [3:0]  channel;
        logic [3:0]  route;
    } t_slot_rec;

endpackage

FILE: design/mnsg_out_stage.sv
// output stage: one-message hold register plus output register, marks tlast
// depends on mnsg_pkg
module mnsg_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mnsg_pkg::t_msg i_msg,
    input  logic          i_fin,
    output logic          o_push_ok,
    output logic          o_fin_ok,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [31:0]   o_m_axis_tdata,   // route, status_byte, data_one, data_two
    output logic          o_m_axis_tlast
);
    import mnsg_pkg::*;

    logic r_hv;
    t_msg r_hold;
    logic r_ov;
    t_msg r_out;
    logic r_last;
    logic w_out_free;

    assign w_out_free = !r_ov || i_m_axis_tready;
    assign o_push_ok  = !r_hv || w_out_free;
    assign o_fin_ok   = !r_hv || w_out_free;

    // hold keeps the newest message until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_push && o_push_ok) begin
                if (r_hv) begin
                    r_out  <= r_hold;
                    r_last <= 1'b0;
                end
                r_ov   <= r_hv || (r_ov && !i_m_axis_tready);
                r_hold <= i_msg;
                r_hv   <= 1'b1;
            end else if (i_fin && r_hv && w_out_free) begin
                r_out  <= r_hold;
                r_last <= 1'b1;
                r_ov   <= 1'b1;
                r_hv   <= 1'b0;
            end else if (r_ov && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {6'd0, r_out};
    assign o_m_axis_tlast  = r_last;

endmodule

FILE: design/midi_note_strum_gate_scheduler_top.sv
// scheduler top: sequencer, note stores, shared compare/subtract; uses mnsg_pkg, mnsg_out_stage
// busy per item, then idle for the next: play now sends off if sounding, then on; delayed play
//   takes the lowest free slot; age pending visits each slot, firing due ones; age bank and kill
//   walk the bank pitches; all-off sends one control change; zero elapsed or unknown only flush
// throughput: one item at a time; output stalls hold the sequencer and its final flush
// reset: synchronous active low; clears sounding, pending valid and configuration registers
module midi_note_strum_gate_scheduler_top #(
    parameter int PENDING_SLOTS = 16,
    parameter int BANK_PITCHES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // command, pitch, velocity, gate_ms, delay_ms, elapsed_ms, bank
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // route, status_byte, data_one, data_two
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_wdata
);
    import mnsg_pkg::*;

    localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int BW = $clog2(BANK_PITCHES);
    localparam int NW = 9;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SLOT   = 11'b00000000010,
        S_PA_RD  = 11'b00000000100,
        S_PA_EV  = 11'b00000001000,
        S_SN_RD  = 11'b00000010000,
        S_SN_OFF = 11'b00000100000,
        S_SN_ON  = 11'b00001000000,
        S_BK_CHK = 11'b00010000000,
        S_BK_EV  = 11'b00100000000,
        S_CC     = 11'b01000000000,
        S_FLUSH  = 11'b10000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0] r_out_channel;
    logic [3:0] r_destination;

    // captured item
    logic [2:0]  r_cmd;
    logic [6:0]  r_pitch;
    logic [6:0]  r_vel;
    logic [15:0] r_gate;
    logic [15:0] r_delay;
    logic [15:0] r_elapsed;
    logic [1:0]  r_bank;

    // sequencer counters and note start arguments
    logic [SW-1:0] r_idx;
    logic [BW-1:0] r_bi;
    logic [6:0]    r_sn_note;
    logic [6:0]    r_sn_vel;
    logic [15:0]   r_sn_gate;
    logic [3:0]    r_sn_ch;
    logic [3:0]    r_sn_route;
    logic          r_from_pend;
    logic [5:0]    r_cnt;

    // state stores
    logic       r_sound [NumPitches];
    logic       r_pvalid [PENDING_SLOTS];
    t_pitch_rec r_pmem [NumPitches];
    t_slot_rec  r_smem [PENDING_SLOTS];
    t_pitch_rec r_pq;
    t_slot_rec  r_sq;

    // combinational
    logic        w_accept;
    logic [NW-1:0] w_n;
    logic [6:0]  w_n7;
    logic        w_req;
    t_msg        w_msg;
    logic        w_push_ok;
    logic        w_fin_ok;
    logic        w_capped;
    logic        w_go;
    logic        w_pre;
    logic [6:0]  w_pra;
    logic        w_pwe;
    logic [6:0]  w_pwa;
    t_pitch_rec  w_pwd;
    logic        w_sre;
    logic        w_swe;
    t_slot_rec   w_swd;
    logic        w_last_slot;
    logic        w_last_bi;
    logic [15:0] w_cmp_a;
    logic        w_le;
    logic [15:0] w_diff;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_n  = NW'(r_bank) * NW'(BANK_PITCHES) + NW'(r_bi);
    assign w_n7 = w_n[6:0];
    assign w_last_slot = (r_idx == SW'(PENDING_SLOTS - 1));
    assign w_last_bi   = (r_bi == BW'(BANK_PITCHES - 1));
    assign w_capped = (r_cnt >= 6'(MaxResults));

    // shared compare and subtract against elapsed time
    assign w_cmp_a = (r_state == S_PA_EV) ? r_sq.delay : r_pq.gate;
    assign w_le    = (w_cmp_a <= r_elapsed);
    assign w_diff  = w_cmp_a - r_elapsed;

    // message request and store port control per state
    always_comb begin
        w_req = 1'b0;
        w_msg = '0;
        w_pre = 1'b0;
        w_pra = r_sn_note;
        w_pwe = 1'b0;
        w_pwa = r_sn_note;
        w_pwd = '{gate: r_sn_gate, channel: r_sn_ch, route: r_sn_route};
        w_sre = 1'b0;
        w_swe = 1'b0;
        w_swd = '{note: r_pitch, velocity: r_vel, gate: r_gate, delay: r_delay,
                  channel: r_out_channel, route: r_destination};
        unique case (r_state)
            S_IDLE, S_FLUSH: begin
            end
            S_SLOT: begin
                w_swe = !r_pvalid[r_idx];
            end
            S_PA_RD: begin
                w_sre = r_pvalid[r_idx];
            end
            S_PA_EV: begin
                w_swe = !w_le;
                w_swd = r_sq;
                w_swd.delay = w_diff;
            end
            S_SN_RD: begin
                w_pre = 1'b1;
            end
            S_SN_OFF: begin
                w_req = r_sound[r_sn_note];
                w_msg = '{data_two: 7'd0, data_one: r_sn_note,
                          status_byte: StatusOff | {4'd0, r_pq.channel},
                          route: r_pq.route};
            end
            S_SN_ON: begin
                w_req = 1'b1;
                w_msg = '{data_two: r_sn_vel, data_one: r_sn_note,
                          status_byte: StatusOn | {4'd0, r_sn_ch}, route: r_sn_route};
                w_pwe = w_go;
            end
            S_BK_CHK: begin
                w_pra = w_n7;
                w_pre = (w_n < NW'(NumPitches)) && r_sound[w_n7];
            end
            S_BK_EV: begin
                w_req = (r_cmd == CmdKillBank) || w_le;
                w_msg = '{data_two: 7'd0, data_one: w_n7,
                          status_byte: StatusOff | {4'd0, r_pq.channel},
                          route: r_pq.route};
                w_pwa = w_n7;
                w_pwe = !w_req;
                w_pwd = r_pq;
                w_pwd.gate = w_diff;
            end
            S_CC: begin
                w_req = 1'b1;
                w_msg = '{data_two: 7'd0, data_one: CcAllOff,
                          status_byte: StatusCc | {4'd0, r_out_channel},
                          route: r_destination};
            end
            default: begin
            end
        endcase
    end

    // a message goes when the output stage takes it or when the limit drops it
    assign w_go = w_req && (w_push_ok || w_capped);

    // pitch store
    always_ff @(posedge i_clk) begin
        if (w_pre) begin
            r_pq <= r_pmem[w_pra];
        end
        if (w_pwe) begin
            r_pmem[w_pwa] <= w_pwd;
        end
    end

    // pending slot store
    always_ff @(posedge i_clk) begin
        if (w_sre) begin
            r_sq <= r_smem[r_idx];
        end
        if (w_swe) begin
            r_smem[r_idx] <= w_swd;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_channel <= '0;
            r_destination <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegOutChannel:  r_out_channel <= i_cfg_wdata;
                RegDestination: r_destination <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            for (int k = 0; k < NumPitches; k++) begin
                r_sound[k] <= 1'b0;
            end
            for (int k = 0; k < PENDING_SLOTS; k++) begin
                r_pvalid[k] <= 1'b0;
            end
        end else begin
            if (w_go && !w_capped) begin
                r_cnt <= r_cnt + 6'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= i_s_axis_tdata[2:0];
                        r_pitch   <= i_s_axis_tdata[9:3];
                        r_vel     <= i_s_axis_tdata[16:10];
                        r_gate    <= i_s_axis_tdata[32:17];
                        r_delay   <= i_s_axis_tdata[48:33];
                        r_elapsed <= i_s_axis_tdata[64:49];
                        r_bank    <= i_s_axis_tdata[66:65];
                        r_sn_note  <= i_s_axis_tdata[9:3];
                        r_sn_vel   <= i_s_axis_tdata[16:10];
                        r_sn_gate  <= i_s_axis_tdata[32:17];
                        r_sn_ch    <= r_out_channel;
                        r_sn_route <= r_destination;
                        r_from_pend <= 1'b0;
                        r_idx <= '0;
                        r_bi  <= '0;
                        r_cnt <= '0;
                        unique case (i_s_axis_tdata[2:0])
                            CmdPlay: begin
                                r_state <= (i_s_axis_tdata[48:33] == 16'd0) ?
                                           S_SN_RD : S_SLOT;
                            end
                            CmdAgePend: begin
                                r_state <= (i_s_axis_tdata[64:49] == 16'd0) ?
                                           S_FLUSH : S_PA_RD;
                            end
                            CmdAgeBank: begin
                                r_state <= (i_s_axis_tdata[64:49] == 16'd0) ?
                                           S_FLUSH : S_BK_CHK;
                            end
                            CmdKillBank: begin
                                for (int k = 0; k < PENDING_SLOTS; k++) begin
                                    r_pvalid[k] <= 1'b0;
                                end
                                r_state <= S_BK_CHK;
                            end
                            CmdAllOff: r_state <= S_CC;
                            default:   r_state <= S_FLUSH;
                        endcase
                    end
                end
                // lowest free slot takes the delayed note
                S_SLOT: begin
                    if (!r_pvalid[r_idx]) begin
                        r_pvalid[r_idx] <= 1'b1;
                        r_state <= S_FLUSH;
                    end else if (w_last_slot) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_PA_RD: begin
                    if (r_pvalid[r_idx]) begin
                        r_state <= S_PA_EV;
                    end else if (w_last_slot) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                // fire a due slot or count its delay down
                S_PA_EV: begin
                    if (w_le) begin
                        r_pvalid[r_idx] <= 1'b0;
                        r_sn_note   <= r_sq.note;
                        r_sn_vel    <= r_sq.velocity;
                        r_sn_gate   <= r_sq.gate;
                        r_sn_ch     <= r_sq.channel;
                        r_sn_route  <= r_sq.route;
                        r_from_pend <= 1'b1;
                        r_state     <= S_SN_RD;
                    end else if (w_last_slot) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx   <= r_idx + SW'(1);
                        r_state <= S_PA_RD;
                    end
                end
                S_SN_RD: begin
                    r_state <= S_SN_OFF;
                end
                S_SN_OFF: begin
                    if (!w_req || w_go) begin
                        r_state <= S_SN_ON;
                    end
                end
                S_SN_ON: begin
                    if (w_go) begin
                        r_sound[r_sn_note] <= 1'b1;
                        if (!r_from_pend || w_last_slot) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx   <= r_idx + SW'(1);
                            r_state <= S_PA_RD;
                        end
                    end
                end
                // walk the bank pitches
                S_BK_CHK: begin
                    if (w_n >= NW'(NumPitches)) begin
                        r_state <= S_FLUSH;
                    end else if (r_sound[w_n7]) begin
                        r_state <= S_BK_EV;
                    end else if (w_last_bi) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_bi <= r_bi + BW'(1);
                    end
                end
                S_BK_EV: begin
                    if (!w_req || w_go) begin
                        if (w_req) begin
                            r_sound[w_n7] <= 1'b0;
                        end
                        if (w_last_bi) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_bi    <= r_bi + BW'(1);
                            r_state <= S_BK_CHK;
                        end
                    end
                end
                S_CC: begin
                    if (w_go) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (w_fin_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mnsg_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_req && !w_capped),
        .i_msg           (w_msg),
        .i_fin           (r_state == S_FLUSH),
        .o_push_ok       (w_push_ok),
        .o_fin_ok        (w_fin_ok),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
